// ----- rtl/hsvd_pkg.sv -----
// Shared types, constants and helper functions of the HSV/RGB LED duty driver.
// Depends on nothing; every other RTL file of the block refers to it by scoped names.
`default_nettype none

package hsvd_pkg;

  localparam int unsigned LevelW   = 8;
  localparam int unsigned HueW     = 9;
  localparam int unsigned DutyW    = 12;
  localparam int unsigned ChanW    = 4;
  localparam int unsigned ActW     = 3;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 4;
  localparam int unsigned SectorW  = 3;
  localparam int unsigned ProdW    = 2 * LevelW;

  typedef enum logic [ActW-1:0] {
    ACT_SET_ALL   = 3'd0,
    ACT_SET_RED   = 3'd1,
    ACT_SET_GREEN = 3'd2,
    ACT_SET_BLUE  = 3'd3,
    ACT_SET_HSV   = 3'd4
  } action_e;

  localparam logic [CfgIdxW-1:0] CFG_COLOR_ORDER  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_BASE_CHANNEL = 1'b1;

  // Hue landmarks in degrees.
  localparam logic [HueW-1:0] HUE_60  = 9'd60;
  localparam logic [HueW-1:0] HUE_120 = 9'd120;
  localparam logic [HueW-1:0] HUE_180 = 9'd180;
  localparam logic [HueW-1:0] HUE_240 = 9'd240;
  localparam logic [HueW-1:0] HUE_300 = 9'd300;
  localparam logic [HueW-1:0] HUE_360 = 9'd360;

  // Divisors handed to the serial multiply-divide unit.
  localparam logic [LevelW-1:0] DIV_CHROMA = 8'd255;
  localparam logic [LevelW-1:0] DIV_SECTOR = 8'd60;

  typedef struct packed {
    logic [ActW-1:0]   action;
    logic [LevelW-1:0] red_in;
    logic [LevelW-1:0] green_in;
    logic [LevelW-1:0] blue_in;
    logic [LevelW-1:0] single_level;
    logic [HueW-1:0]   hue;
    logic [LevelW-1:0] saturation;
    logic [LevelW-1:0] brightness;
  } in_item_t;

  typedef struct packed {
    logic [ChanW-1:0] target_channel;
    logic [DutyW-1:0] duty_first;
    logic [DutyW-1:0] duty_second;
    logic [DutyW-1:0] duty_third;
  } out_item_t;

  // Request to the multiply-divide unit: quotient = mcand * mplier / divisor.
  typedef struct packed {
    logic              start;
    logic [LevelW-1:0] mcand;
    logic [LevelW-1:0] mplier;
    logic [LevelW-1:0] divisor;
  } md_req_t;

  typedef struct packed {
    logic              done;
    logic [LevelW-1:0] quotient;
  } md_rsp_t;

  // x * 4095 / 255 equals 16x + x/17; x/17 is taken as (x * 241) >> 12,
  // which is exact for all 8-bit x.
  function automatic logic [DutyW-1:0] level_to_duty(input logic [LevelW-1:0] lvl);
    logic [ProdW-1:0] prod;
    begin
      prod = {{LevelW{1'b0}}, lvl} * 16'd241;
      return {lvl, 4'b0000} + {8'd0, prod[15:12]};
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/hsvd_muldiv.sv -----
// Bit-serial multiply-divide unit: one multiplier bit per cycle, then one quotient bit per cycle.
// Depends on hsvd_pkg for the request and response structs.
`default_nettype none

module hsvd_muldiv (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire hsvd_pkg::md_req_t req_i,
  output hsvd_pkg::md_rsp_t     rsp_o
);

  localparam int unsigned CntW = $clog2(hsvd_pkg::LevelW);
  localparam logic [CntW-1:0] LastStep = CntW'(hsvd_pkg::LevelW - 1);

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_e;

  md_state_e                        state_q;
  logic [CntW-1:0]                  cnt_q;
  logic                             done_q;
  logic [hsvd_pkg::ProdW-1:0]       mcand_q;
  logic [hsvd_pkg::LevelW-1:0]      mplier_q;
  logic [hsvd_pkg::ProdW-1:0]       acc_q;
  logic [hsvd_pkg::LevelW-1:0]      rem_q;
  logic [hsvd_pkg::LevelW-1:0]      low_q;
  logic [hsvd_pkg::LevelW-1:0]      quot_q;
  logic [hsvd_pkg::LevelW-1:0]      div_q;

  logic [hsvd_pkg::ProdW-1:0]       acc_sum;
  logic [hsvd_pkg::LevelW:0]        trial;
  logic [hsvd_pkg::LevelW:0]        trial_diff;
  logic                             fits;
  logic [hsvd_pkg::LevelW-1:0]      rem_next;

  // The product's upper byte is always below the divisor, so the quotient fits
  // in one byte and the partial remainder never needs more than a byte.
  always_comb begin
    acc_sum    = mplier_q[0] ? (acc_q + mcand_q) : acc_q;
    trial      = {rem_q, low_q[hsvd_pkg::LevelW-1]};
    trial_diff = trial - {1'b0, div_q};
    fits       = (trial >= {1'b0, div_q});
    rem_next   = fits ? trial_diff[hsvd_pkg::LevelW-1:0] : trial[hsvd_pkg::LevelW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        MD_IDLE: begin
          if (req_i.start) begin
            cnt_q   <= '0;
            state_q <= MD_MUL;
          end
        end
        MD_MUL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LastStep) begin
            cnt_q   <= '0;
            state_q <= MD_DIV;
          end
        end
        MD_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == LastStep) begin
            cnt_q   <= '0;
            done_q  <= 1'b1;
            state_q <= MD_IDLE;
          end
        end
        default: state_q <= MD_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      MD_IDLE: begin
        if (req_i.start) begin
          mcand_q  <= {{hsvd_pkg::LevelW{1'b0}}, req_i.mcand};
          mplier_q <= req_i.mplier;
          div_q    <= req_i.divisor;
          acc_q    <= '0;
        end
      end
      MD_MUL: begin
        acc_q    <= acc_sum;
        mcand_q  <= {mcand_q[hsvd_pkg::ProdW-2:0], 1'b0};
        mplier_q <= {1'b0, mplier_q[hsvd_pkg::LevelW-1:1]};
        if (cnt_q == LastStep) begin
          rem_q <= acc_sum[hsvd_pkg::ProdW-1:hsvd_pkg::LevelW];
          low_q <= acc_sum[hsvd_pkg::LevelW-1:0];
        end
      end
      MD_DIV: begin
        rem_q  <= rem_next;
        low_q  <= {low_q[hsvd_pkg::LevelW-2:0], 1'b0};
        quot_q <= {quot_q[hsvd_pkg::LevelW-2:0], fits};
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quot_q;

endmodule

`default_nettype wire

// ----- rtl/hsv_to_rgb_pwm_driver.sv -----
// Top level of the HSV/RGB LED duty driver: command decode, level registers, output register.
// Depends on hsvd_pkg and instantiates hsvd_muldiv.
//
// Usage: each input transaction on in_valid_i/in_stall_o either sets all three levels, sets
// one level, or sets a color from hue, saturation and brightness. Every input transaction
// yields exactly one output transaction on out_valid_o/out_stall_i that carries the base PWM
// channel and the three current levels scaled to 12-bit duties, in red-green-blue order when
// color_order is 1 and green-red-blue order otherwise.
// Sequence: a direct level write sets the levels when accepted, then passes through the
// emit step into the output register. An HSV transaction runs the bit-serial
// multiply-divide unit twice (chroma, then the secondary component). Each pass loads its
// operands and runs 8 multiply steps and 8 divide steps; then the levels are written and
// the output register is loaded from the emit step.
// Flow: one transaction at a time; a new one is accepted only after the last has left the
// emit step. in_stall_o is low whenever no transaction is in work, even while a finished
// result still waits on the output side.
// Reset clears the levels, the configuration and the output valid flag.
// When the receiver stalls, the output register holds its transaction; a second result
// waits in the emit step, and the input stays stalled until the output register frees up.
// Configuration is written through cfg_we_i/cfg_index_i/cfg_wdata_i. The user must write it
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module hsv_to_rgb_pwm_driver (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire hsvd_pkg::in_item_t                in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output hsvd_pkg::out_item_t                    out_data_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [hsvd_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [hsvd_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHROMA,
    S_XVAL,
    S_EMIT
  } state_e;

  state_e                           state_q;
  logic                             color_order_q;
  logic [hsvd_pkg::ChanW-1:0]       base_channel_q;
  logic [hsvd_pkg::LevelW-1:0]      red_q;
  logic [hsvd_pkg::LevelW-1:0]      green_q;
  logic [hsvd_pkg::LevelW-1:0]      blue_q;
  logic                             out_valid_q;
  hsvd_pkg::out_item_t              out_data_q;

  // Working registers of an HSV transaction.
  logic [hsvd_pkg::SectorW-1:0]     sector_q;
  logic [hsvd_pkg::LevelW-1:0]      xmul_q;
  logic [hsvd_pkg::LevelW-1:0]      val_q;
  logic [hsvd_pkg::LevelW-1:0]      chroma_q;

  hsvd_pkg::md_req_t                md_req;
  hsvd_pkg::md_rsp_t                md_rsp;

  logic                             in_accept;
  logic                             out_load;
  logic [hsvd_pkg::HueW-1:0]        hue_mod;
  logic [hsvd_pkg::HueW-1:0]        hue_base;
  logic [hsvd_pkg::HueW-1:0]        hue_in_third;
  logic [hsvd_pkg::HueW-1:0]        hue_dist;
  logic [hsvd_pkg::HueW-1:0]        xmul_wide;
  logic [hsvd_pkg::SectorW-1:0]     sector;
  logic [hsvd_pkg::LevelW-1:0]      m_off;
  logic [hsvd_pkg::LevelW-1:0]      x_comp;
  logic [hsvd_pkg::LevelW-1:0]      hsv_red;
  logic [hsvd_pkg::LevelW-1:0]      hsv_green;
  logic [hsvd_pkg::LevelW-1:0]      hsv_blue;
  logic [hsvd_pkg::DutyW-1:0]       duty_red;
  logic [hsvd_pkg::DutyW-1:0]       duty_green;
  logic [hsvd_pkg::DutyW-1:0]       duty_blue;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  // Hue decode: reduce to one turn, find the 60-degree sector and the distance of the
  // hue from the middle of its 120-degree third, which sets the secondary component.
  always_comb begin
    hue_mod = (in_data_i.hue >= hsvd_pkg::HUE_360) ? (in_data_i.hue - hsvd_pkg::HUE_360)
                                                   : in_data_i.hue;
    if (hue_mod >= hsvd_pkg::HUE_300) begin
      sector = 3'd5;
    end else if (hue_mod >= hsvd_pkg::HUE_240) begin
      sector = 3'd4;
    end else if (hue_mod >= hsvd_pkg::HUE_180) begin
      sector = 3'd3;
    end else if (hue_mod >= hsvd_pkg::HUE_120) begin
      sector = 3'd2;
    end else if (hue_mod >= hsvd_pkg::HUE_60) begin
      sector = 3'd1;
    end else begin
      sector = 3'd0;
    end
    if (hue_mod >= hsvd_pkg::HUE_240) begin
      hue_base = hsvd_pkg::HUE_240;
    end else if (hue_mod >= hsvd_pkg::HUE_120) begin
      hue_base = hsvd_pkg::HUE_120;
    end else begin
      hue_base = '0;
    end
    hue_in_third = hue_mod - hue_base;
    hue_dist = (hue_in_third >= hsvd_pkg::HUE_60) ? (hue_in_third - hsvd_pkg::HUE_60)
                                                  : (hsvd_pkg::HUE_60 - hue_in_third);
    xmul_wide = hsvd_pkg::HUE_60 - hue_dist;
  end

  // The serial unit first forms V*S/255 from the input fields, then C*(60-dist)/60.
  always_comb begin
    md_req.start   = (in_accept && (in_data_i.action == hsvd_pkg::ACT_SET_HSV))
                   || ((state_q == S_CHROMA) && md_rsp.done);
    md_req.mcand   = (state_q == S_IDLE) ? in_data_i.brightness : md_rsp.quotient;
    md_req.mplier  = (state_q == S_IDLE) ? in_data_i.saturation : xmul_q;
    md_req.divisor = (state_q == S_IDLE) ? hsvd_pkg::DIV_CHROMA : hsvd_pkg::DIV_SECTOR;
  end

  hsvd_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  // Sector table: the largest component gets C, the secondary one X, and all get the offset m.
  // C + m never exceeds V, so the sums always fit in a byte.
  always_comb begin
    x_comp = md_rsp.quotient;
    m_off  = val_q - chroma_q;
    case (sector_q)
      3'd0: begin
        hsv_red   = chroma_q + m_off;
        hsv_green = x_comp + m_off;
        hsv_blue  = m_off;
      end
      3'd1: begin
        hsv_red   = x_comp + m_off;
        hsv_green = chroma_q + m_off;
        hsv_blue  = m_off;
      end
      3'd2: begin
        hsv_red   = m_off;
        hsv_green = chroma_q + m_off;
        hsv_blue  = x_comp + m_off;
      end
      3'd3: begin
        hsv_red   = m_off;
        hsv_green = x_comp + m_off;
        hsv_blue  = chroma_q + m_off;
      end
      3'd4: begin
        hsv_red   = x_comp + m_off;
        hsv_green = m_off;
        hsv_blue  = chroma_q + m_off;
      end
      default: begin
        hsv_red   = chroma_q + m_off;
        hsv_green = m_off;
        hsv_blue  = x_comp + m_off;
      end
    endcase
  end

  always_comb begin
    duty_red   = hsvd_pkg::level_to_duty(red_q);
    duty_green = hsvd_pkg::level_to_duty(green_q);
    duty_blue  = hsvd_pkg::level_to_duty(blue_q);
  end

  // Control state, configuration, levels and the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      color_order_q  <= 1'b0;
      base_channel_q <= '0;
      red_q          <= '0;
      green_q        <= '0;
      blue_q         <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          hsvd_pkg::CFG_COLOR_ORDER:  color_order_q  <= cfg_wdata_i[0];
          hsvd_pkg::CFG_BASE_CHANNEL: base_channel_q <= cfg_wdata_i;
          default:                    color_order_q  <= color_order_q;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            case (in_data_i.action)
              hsvd_pkg::ACT_SET_ALL: begin
                red_q   <= in_data_i.red_in;
                green_q <= in_data_i.green_in;
                blue_q  <= in_data_i.blue_in;
                state_q <= S_EMIT;
              end
              hsvd_pkg::ACT_SET_RED: begin
                red_q   <= in_data_i.single_level;
                state_q <= S_EMIT;
              end
              hsvd_pkg::ACT_SET_GREEN: begin
                green_q <= in_data_i.single_level;
                state_q <= S_EMIT;
              end
              hsvd_pkg::ACT_SET_BLUE: begin
                blue_q  <= in_data_i.single_level;
                state_q <= S_EMIT;
              end
              hsvd_pkg::ACT_SET_HSV:   state_q <= S_CHROMA;
              default:                 state_q <= S_EMIT;
            endcase
          end
        end
        S_CHROMA: begin
          if (md_rsp.done) begin
            state_q <= S_XVAL;
          end
        end
        S_XVAL: begin
          if (md_rsp.done) begin
            red_q   <= hsv_red;
            green_q <= hsv_green;
            blue_q  <= hsv_blue;
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sector_q <= sector;
      xmul_q   <= xmul_wide[hsvd_pkg::LevelW-1:0];
      val_q    <= in_data_i.brightness;
    end
    if ((state_q == S_CHROMA) && md_rsp.done) begin
      chroma_q <= md_rsp.quotient;
    end
    if (out_load) begin
      out_data_q.target_channel <= base_channel_q;
      out_data_q.duty_first     <= color_order_q ? duty_red : duty_green;
      out_data_q.duty_second    <= color_order_q ? duty_green : duty_red;
      out_data_q.duty_third     <= duty_blue;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A new result enters the output register only from the emit step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EMIT))
    else $error("output valid rose without an emit step");

  // The serial unit only reports completion while an HSV transaction waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_rsp.done |-> ((state_q == S_CHROMA) || (state_q == S_XVAL)))
    else $error("multiply-divide completion outside an HSV transaction");

  // An accepted HSV transaction starts the chroma computation in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (in_data_i.action == hsvd_pkg::ACT_SET_HSV)) |=> (state_q == S_CHROMA))
    else $error("HSV transaction did not start the chroma step");

  // The emit step leaves only once the output register has taken its result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_EMIT) && !out_load) |=> (state_q == S_EMIT))
    else $error("emit step left without loading the output register");

endmodule

`default_nettype wire
